// ===== design/fat12ccs_pkg.sv =====
// Package for the FAT12 cluster chain sequencer: types, codes and sizes.
// Used by fat12_cluster_chain_sequencer and its testbench; depends on nothing.
`default_nettype none

package fat12ccs_pkg;

  // Table store size in bytes (512 to 8192) and its address width
  localparam int unsigned FAT_BYTES = 8192;
  localparam int unsigned FAT_AW    = $clog2(FAT_BYTES);

  // Chain constants
  localparam logic [11:0] END_MARK   = 12'hFF8;
  localparam logic [7:0]  SPC_MAX    = 8'd128;
  localparam logic [12:0] CLUSTER_OFS = 13'd2;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_OPEN    = 2'd1,
    KIND_ADVANCE = 2'd2
  } kind_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_DATA_LBA = 2'd0;
  localparam logic [1:0] CFG_SPC      = 2'd1;
  localparam logic [1:0] CFG_ROOT_LBA = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH_LO,
    ST_FETCH_HI,
    ST_FETCH_END,
    ST_MUL,
    ST_ADD_BASE,
    ST_ADD_SEC,
    ST_ROOT_INC,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== design/fat12_cluster_chain_sequencer.sv =====
// Top level of the FAT12 cluster chain sequencer: sequencer, shared adder, table RAM.
// Depends on fat12ccs_pkg and fat12ccs_ram.
`default_nettype none

// Walks the sectors of a FAT12 file chain or of the fixed root directory.
// Load words write one byte of the FAT table into an internal RAM; open words
// start a file chain at first_cluster_i (or the root directory when
// open_root_i is set) and return the first sector address; advance words step
// one sector and return the new address, fetching the next 12-bit table entry
// when a cluster is used up. An entry of 0xFF8 or above ends the chain, after
// which results carry end_of_chain_o = 1 and sector_lba_o = 0. Load words
// give no result; a root open goes straight to output, a root advance first
// adds one to the root sector address. A file open or advance multiplies the
// cluster offset by sectors_per_cluster, then the one 32-bit adder adds the
// data base and the sector index in two passes; an advance into a new cluster
// first reads the two entry bytes one after the other through the single RAM
// port and decodes the entry, ending there at the end mark. An open at or
// above the end mark, or an advance on an ended chain, goes straight to
// output. A result waits while a previous one is held in the stalled output
// register. The input is stalled while a word is in work; a finished result
// waits in the output register, and the next word is taken meanwhile.
module fat12_cluster_chain_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [12:0] fat_index_i,
  input  wire logic [7:0]  fat_byte_i,
  input  wire logic [11:0] first_cluster_i,
  input  wire logic        open_root_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      sector_lba_o,
  output logic [11:0]      cluster_now_o,
  output logic             end_of_chain_o
);

  localparam int unsigned AW = fat12ccs_pkg::FAT_AW;
  localparam logic [13:0] FatBytes14 = 14'(fat12ccs_pkg::FAT_BYTES);

  fat12ccs_pkg::state_e state_q, state_d;

  // configuration registers
  logic [31:0] data_lba_q, root_dir_q;
  logic [7:0]  spc_q;

  // walk state
  logic [11:0] cluster_q, cluster_d;
  logic [6:0]  sic_q, sic_d;
  logic [31:0] root_lba_q, root_lba_d;
  logic        root_mode_q, root_mode_d;
  logic        done_q, done_d;

  // work registers
  logic [12:0] addr_q, addr_d;
  logic [7:0]  lo_byte_q, lo_byte_d;
  logic        rd_ok_q, rd_ok_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] acc_q, acc_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_lba_q, out_lba_d;
  logic [11:0] out_cl_q, out_cl_d;
  logic        out_eoc_q, out_eoc_d;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  logic                accept;
  fat12ccs_pkg::kind_e kind;
  logic [7:0]          spc_eff;
  logic [7:0]          sic_inc;
  logic [12:0]         entry_at;
  logic [12:0]         entry_next;
  logic [7:0]          hi_byte;
  logic [15:0]         entry_word;
  logic [11:0]         next_cl;
  logic [12:0]         cl_diff;
  logic [31:0]         mul_full;
  logic [31:0]         add_a, add_b, add_sum;
  logic                out_free;

  assign accept   = in_valid_i && (state_q == fat12ccs_pkg::ST_IDLE);
  assign kind     = fat12ccs_pkg::kind_e'(kind_i);
  assign out_free = !out_valid_q || !out_stall_i;

  // sectors per cluster, clipped to the largest legal value
  assign spc_eff = (spc_q > fat12ccs_pkg::SPC_MAX) ? fat12ccs_pkg::SPC_MAX : spc_q;
  assign sic_inc = {1'b0, sic_q} + 8'd1;

  // byte address of an entry: cluster * 3 / 2
  assign entry_at   = {1'b0, cluster_q} + {2'b0, cluster_q[11:1]};
  assign entry_next = addr_q + 13'd1;

  // entry decode from the two little-endian bytes
  assign hi_byte    = rd_ok_q ? ram_rdata : 8'd0;
  assign entry_word = {hi_byte, lo_byte_q};
  assign next_cl    = cluster_q[0] ? entry_word[15:4] : entry_word[11:0];

  // cluster offset times sectors per cluster, modulo 2^32
  assign cl_diff  = {1'b0, cluster_q} - fat12ccs_pkg::CLUSTER_OFS;
  assign mul_full = {{19{cl_diff[12]}}, cl_diff} * {24'd0, spc_eff};

  // shared 32-bit adder
  always_comb begin
    add_a = 32'd0;
    add_b = 32'd0;
    case (state_q)
      fat12ccs_pkg::ST_ADD_BASE: begin
        add_a = data_lba_q;
        add_b = prod_q;
      end
      fat12ccs_pkg::ST_ADD_SEC: begin
        add_a = acc_q;
        add_b = {25'd0, sic_q};
      end
      fat12ccs_pkg::ST_ROOT_INC: begin
        add_a = root_lba_q;
        add_b = 32'd1;
      end
      default: begin
        add_a = 32'd0;
        add_b = 32'd0;
      end
    endcase
  end
  assign add_sum = add_a + add_b;

  // sequencer: next state, walk state and RAM port
  always_comb begin
    state_d     = state_q;
    cluster_d   = cluster_q;
    sic_d       = sic_q;
    root_lba_d  = root_lba_q;
    root_mode_d = root_mode_q;
    done_d      = done_q;
    addr_d      = addr_q;
    lo_byte_d   = lo_byte_q;
    rd_ok_d     = rd_ok_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_lba_d   = out_lba_q;
    out_cl_d    = out_cl_q;
    out_eoc_d   = out_eoc_q;
    ram_we      = 1'b0;
    ram_addr    = fat_index_i[AW-1:0];

    case (state_q)
      fat12ccs_pkg::ST_IDLE: begin
        if (accept) begin
          case (kind)
            fat12ccs_pkg::KIND_LOAD: begin
              ram_we = ({1'b0, fat_index_i} < FatBytes14);
            end
            fat12ccs_pkg::KIND_OPEN: begin
              sic_d = 7'd0;
              if (open_root_i) begin
                root_mode_d = 1'b1;
                root_lba_d  = root_dir_q;
                cluster_d   = 12'd0;
                done_d      = 1'b0;
                state_d     = fat12ccs_pkg::ST_EMIT;
              end else begin
                root_mode_d = 1'b0;
                cluster_d   = first_cluster_i;
                done_d      = (first_cluster_i >= fat12ccs_pkg::END_MARK);
                state_d     = (first_cluster_i >= fat12ccs_pkg::END_MARK) ?
                              fat12ccs_pkg::ST_EMIT : fat12ccs_pkg::ST_MUL;
              end
            end
            fat12ccs_pkg::KIND_ADVANCE: begin
              if (root_mode_q) begin
                state_d = fat12ccs_pkg::ST_ROOT_INC;
              end else if (done_q) begin
                state_d = fat12ccs_pkg::ST_EMIT;
              end else if (sic_inc >= spc_eff) begin
                sic_d   = 7'd0;
                state_d = fat12ccs_pkg::ST_FETCH_LO;
              end else begin
                sic_d   = sic_inc[6:0];
                state_d = fat12ccs_pkg::ST_MUL;
              end
            end
            default: begin
              state_d = fat12ccs_pkg::ST_IDLE;
            end
          endcase
        end
      end

      // read the low entry byte
      fat12ccs_pkg::ST_FETCH_LO: begin
        ram_addr = entry_at[AW-1:0];
        addr_d   = entry_at;
        rd_ok_d  = ({1'b0, entry_at} < FatBytes14);
        state_d  = fat12ccs_pkg::ST_FETCH_HI;
      end

      // take the low byte, read the high byte
      fat12ccs_pkg::ST_FETCH_HI: begin
        ram_addr  = entry_next[AW-1:0];
        lo_byte_d = rd_ok_q ? ram_rdata : 8'd0;
        rd_ok_d   = ({1'b0, entry_next} < FatBytes14);
        state_d   = fat12ccs_pkg::ST_FETCH_END;
      end

      // take the high byte and move to the next cluster
      fat12ccs_pkg::ST_FETCH_END: begin
        cluster_d = next_cl;
        done_d    = (next_cl >= fat12ccs_pkg::END_MARK);
        state_d   = (next_cl >= fat12ccs_pkg::END_MARK) ?
                    fat12ccs_pkg::ST_EMIT : fat12ccs_pkg::ST_MUL;
      end

      fat12ccs_pkg::ST_MUL: begin
        prod_d  = mul_full;
        state_d = fat12ccs_pkg::ST_ADD_BASE;
      end

      fat12ccs_pkg::ST_ADD_BASE: begin
        acc_d   = add_sum;
        state_d = fat12ccs_pkg::ST_ADD_SEC;
      end

      fat12ccs_pkg::ST_ADD_SEC: begin
        acc_d   = add_sum;
        state_d = fat12ccs_pkg::ST_EMIT;
      end

      fat12ccs_pkg::ST_ROOT_INC: begin
        root_lba_d = add_sum;
        state_d    = fat12ccs_pkg::ST_EMIT;
      end

      // hand the result to the output register once it is free
      fat12ccs_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (root_mode_q) begin
            out_lba_d = root_lba_q;
            out_cl_d  = 12'd0;
            out_eoc_d = 1'b0;
          end else if (done_q) begin
            out_lba_d = 32'd0;
            out_cl_d  = cluster_q;
            out_eoc_d = 1'b1;
          end else begin
            out_lba_d = acc_q;
            out_cl_d  = cluster_q;
            out_eoc_d = 1'b0;
          end
          state_d = fat12ccs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = fat12ccs_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fat12ccs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_lba_q  <= 32'd0;
      spc_q       <= 8'd1;
      root_dir_q  <= 32'd0;
      cluster_q   <= 12'd0;
      sic_q       <= 7'd0;
      root_lba_q  <= 32'd0;
      root_mode_q <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          fat12ccs_pkg::CFG_DATA_LBA: data_lba_q <= cfg_data_i;
          fat12ccs_pkg::CFG_SPC:      spc_q      <= cfg_data_i[7:0];
          fat12ccs_pkg::CFG_ROOT_LBA: root_dir_q <= cfg_data_i;
          default: ;
        endcase
      end
      cluster_q   <= cluster_d;
      sic_q       <= sic_d;
      root_lba_q  <= root_lba_d;
      root_mode_q <= root_mode_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    lo_byte_q <= lo_byte_d;
    rd_ok_q   <= rd_ok_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    out_lba_q <= out_lba_d;
    out_cl_q  <= out_cl_d;
    out_eoc_q <= out_eoc_d;
  end

  // FAT table store
  fat12ccs_ram #(
    .Width(8),
    .Depth(fat12ccs_pkg::FAT_BYTES)
  ) u_fat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (fat_byte_i),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o     = (state_q != fat12ccs_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign sector_lba_o   = out_lba_q;
  assign cluster_now_o  = out_cl_q;
  assign end_of_chain_o = out_eoc_q;

endmodule

`default_nettype wire

// ===== design/fat12ccs_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing; instanced by fat12_cluster_chain_sequencer for the table.
`default_nettype none

module fat12ccs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write when enabled; the addressed word is read into the output register in any case (old data on a write)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire
